// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the filter checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, also checked during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/mcmf_pkg.sv
// ----------------------------------------------------------------------------
// mcmf_pkg
// Types, constants and tables shared by the MIDI channel filter.
// ----------------------------------------------------------------------------
package mcmf_pkg;

	localparam int unsigned MAX_DELAY_UNITS_DEF = 60;
	localparam int unsigned QUEUE_DEPTH_DEF     = 4;
	localparam int unsigned DELAY_W             = 14;
	localparam int unsigned TICKS_PER_UNIT      = 240;

	localparam logic       OP_DATA = 1'b0;
	localparam logic       OP_END  = 1'b1;

	localparam logic [7:0] TICK_BYTE   = 8'hF8;
	localparam logic [7:0] SYSEX_START = 8'hF0;
	localparam logic [7:0] SYSEX_END   = 8'hF7;
	localparam logic [7:0] END_OF_CH   = 8'hFC;
	localparam logic [7:0] META_BYTE   = 8'hFF;
	localparam logic [7:0] END_TRACK   = 8'h2F;
	localparam logic [3:0] SYS_CHANNEL = 4'hF;
	localparam logic [2:0] END_LAST    = 3'd4;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_in_run;
	} out_item_t;

	typedef struct packed {
		logic               is_end;
		logic               has_delay;
		logic [DELAY_W-1:0] delay;
		logic               has_status;
		logic [7:0]         status;
		logic               has_data;
		logic [7:0]         data;
	} cmd_t;

	function automatic logic [1:0] param_count(input logic [2:0] kind);
		logic [1:0] cnt;
		unique case (kind)
			3'd4, 3'd5: cnt = 2'd1;
			3'd7:       cnt = 2'd0;
			default:    cnt = 2'd2;
		endcase
		return cnt;
	endfunction

	function automatic logic [7:0] end_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd1:    b = META_BYTE;
			3'd2:    b = END_TRACK;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/core/mcmf_queue.sv
// ----------------------------------------------------------------------------
// mcmf_queue
// Small command queue between the parser and the byte emitter.
// ----------------------------------------------------------------------------
module mcmf_queue import mcmf_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign head    = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/mcmf_front.sv
// ----------------------------------------------------------------------------
// mcmf_front
// Parses the delta-timed byte stream, applies the channel mask and queues
// one emit command per request that produces output.
// ----------------------------------------------------------------------------
module mcmf_front import mcmf_pkg::*; #(
	parameter int unsigned MAX_DELAY_UNITS = MAX_DELAY_UNITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output logic        push,
	output cmd_t        push_cmd,
	input  logic        full
);

	localparam logic [DELAY_W:0] DELAY_LIMIT = (DELAY_W + 1)'(MAX_DELAY_UNITS * TICKS_PER_UNIT);
	localparam logic [7:0]       TICK_VALUE  = 8'(TICKS_PER_UNIT);

	typedef enum logic [3:0] {
		F_DELAY = 4'b0001,
		F_EVENT = 4'b0010,
		F_PARAM = 4'b0100,
		F_SYSEX = 4'b1000
	} fphase_t;

	fphase_t            phase_q, n_phase;
	logic [DELAY_W-1:0] pending_q, n_pending;
	logic [7:0]         status_q, n_status;
	logic [3:0]         channel_q, n_channel;
	logic [1:0]         pcount_q, n_pcount;
	logic [7:0]         last_status_q, n_last_status;
	logic               kept_q, n_kept;
	logic [1:0]         togo_q, n_togo;
	logic [15:0]        mask_q;

	logic               accept;
	logic               push_c;
	cmd_t               cmd_c;
	logic [7:0]         c;
	logic               high;
	logic [7:0]         add_val;
	logic [DELAY_W:0]   sum;
	logic [7:0]         ev_status;
	logic [3:0]         ev_channel;
	logic [1:0]         ev_pcount;
	logic               ev_kept;
	logic [1:0]         ev_togo;

	assign in_stall = full;
	assign accept   = in_valid && !full;
	assign push     = accept && push_c;
	assign push_cmd = cmd_c;

	assign c       = in_data.data_byte;
	assign high    = c[7];
	assign add_val = (c == TICK_BYTE) ? TICK_VALUE : c;
	assign sum     = {1'b0, pending_q} + {{(DELAY_W - 7){1'b0}}, add_val};

	always_comb begin
		ev_status  = status_q;
		ev_channel = channel_q;
		ev_pcount  = pcount_q;
		if (c == SYSEX_START || c == END_OF_CH) begin
			ev_status  = c;
			ev_channel = SYS_CHANNEL;
		end else if (high) begin
			ev_status  = c;
			ev_channel = c[3:0];
			ev_pcount  = param_count(c[6:4]);
		end
		ev_kept = mask_q[ev_channel];
		if (high) begin
			ev_togo = ev_pcount;
		end else begin
			ev_togo = (ev_pcount > 2'd1) ? ev_pcount - 2'd1 : 2'd0;
		end
	end

	always_comb begin
		n_phase       = phase_q;
		n_pending     = pending_q;
		n_status      = status_q;
		n_channel     = channel_q;
		n_pcount      = pcount_q;
		n_last_status = last_status_q;
		n_kept        = kept_q;
		n_togo        = togo_q;
		push_c        = 1'b0;
		cmd_c         = '0;
		cmd_c.delay   = pending_q;
		cmd_c.status  = ev_status;
		cmd_c.data    = c;

		if (in_data.opcode == OP_END) begin
			push_c        = 1'b1;
			cmd_c.is_end  = 1'b1;
			n_phase       = F_DELAY;
			n_pending     = '0;
			n_status      = 8'h00;
			n_channel     = SYS_CHANNEL;
			n_pcount      = 2'd0;
			n_last_status = 8'h00;
			n_kept        = 1'b0;
			n_togo        = 2'd0;
		end else begin
			unique case (phase_q)
				F_EVENT: begin
					n_status  = ev_status;
					n_channel = ev_channel;
					n_pcount  = ev_pcount;
					n_kept    = ev_kept;
					if (ev_status == END_OF_CH) begin
						n_phase = F_DELAY;
					end else if (ev_status == SYSEX_START) begin
						if (ev_kept) begin
							push_c           = 1'b1;
							cmd_c.has_delay  = 1'b1;
							cmd_c.has_status = 1'b1;
							n_pending        = '0;
							n_last_status    = SYSEX_START;
						end
						n_phase = F_SYSEX;
					end else begin
						n_togo = ev_togo;
						if (ev_kept) begin
							push_c           = 1'b1;
							cmd_c.has_delay  = 1'b1;
							cmd_c.has_status = (last_status_q != ev_status);
							cmd_c.has_data   = !high && (ev_pcount != 2'd0);
							n_pending        = '0;
							n_last_status    = ev_status;
						end
						n_phase = (ev_togo != 2'd0) ? F_PARAM : F_DELAY;
					end
				end
				F_PARAM: begin
					push_c         = kept_q;
					cmd_c.has_data = 1'b1;
					n_togo         = (togo_q != 2'd0) ? togo_q - 2'd1 : 2'd0;
					if (togo_q <= 2'd1) begin
						n_phase = F_DELAY;
					end
				end
				F_SYSEX: begin
					push_c         = kept_q;
					cmd_c.has_data = 1'b1;
					if (c == SYSEX_END) begin
						n_phase = F_DELAY;
					end
				end
				default: begin
					n_pending = (sum > DELAY_LIMIT) ? DELAY_LIMIT[DELAY_W-1:0] : sum[DELAY_W-1:0];
					n_phase   = (c == TICK_BYTE) ? F_DELAY : F_EVENT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= F_DELAY;
			pending_q     <= '0;
			status_q      <= 8'h00;
			channel_q     <= SYS_CHANNEL;
			pcount_q      <= 2'd0;
			last_status_q <= 8'h00;
			kept_q        <= 1'b0;
			togo_q        <= 2'd0;
			mask_q        <= 16'hFFFF;
		end else begin
			if (cfg_we) begin
				mask_q <= cfg_wdata;
			end
			if (accept) begin
				phase_q       <= n_phase;
				pending_q     <= n_pending;
				status_q      <= n_status;
				channel_q     <= n_channel;
				pcount_q      <= n_pcount;
				last_status_q <= n_last_status;
				kept_q        <= n_kept;
				togo_q        <= n_togo;
			end
		end
	end

endmodule

// File: rtl/core/mcmf_back.sv
// ----------------------------------------------------------------------------
// mcmf_back
// Expands queued commands into output bytes: delay run, status, data byte
// or the end-of-track sequence, through a registered output stage.
// ----------------------------------------------------------------------------
module mcmf_back import mcmf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      empty,
	input  cmd_t      head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam logic [DELAY_W-1:0] TICKS = DELAY_W'(TICKS_PER_UNIT);

	typedef enum logic [4:0] {
		B_IDLE   = 5'b00001,
		B_DELAY  = 5'b00010,
		B_STATUS = 5'b00100,
		B_DATA   = 5'b01000,
		B_END    = 5'b10000
	} bphase_t;

	bphase_t            phase_q, n_phase;
	cmd_t               cmd_q;
	logic [DELAY_W-1:0] delay_q, n_delay;
	logic [2:0]         end_idx_q, n_end_idx;
	logic               out_valid_q;
	out_item_t          out_q, n_out;
	logic               out_free;
	logic               emit;

	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (phase_q == B_IDLE) && !empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		n_phase   = phase_q;
		n_delay   = delay_q;
		n_end_idx = end_idx_q;
		n_out     = out_q;
		emit      = 1'b0;
		unique case (phase_q)
			B_IDLE: begin
				n_delay   = head.delay;
				n_end_idx = 3'd0;
				if (!empty) begin
					if (head.is_end) begin
						n_phase = B_END;
					end else if (head.has_delay) begin
						n_phase = B_DELAY;
					end else if (head.has_status) begin
						n_phase = B_STATUS;
					end else begin
						n_phase = B_DATA;
					end
				end
			end
			B_DELAY: begin
				emit = out_free;
				if (delay_q > TICKS) begin
					n_out = '{out_byte: TICK_BYTE, last_in_run: 1'b0};
					if (out_free) begin
						n_delay = delay_q - TICKS;
					end
				end else begin
					n_out = '{out_byte: delay_q[7:0],
						last_in_run: !cmd_q.has_status && !cmd_q.has_data};
					if (out_free) begin
						if (cmd_q.has_status) begin
							n_phase = B_STATUS;
						end else if (cmd_q.has_data) begin
							n_phase = B_DATA;
						end else begin
							n_phase = B_IDLE;
						end
					end
				end
			end
			B_STATUS: begin
				emit  = out_free;
				n_out = '{out_byte: cmd_q.status, last_in_run: !cmd_q.has_data};
				if (out_free) begin
					n_phase = cmd_q.has_data ? B_DATA : B_IDLE;
				end
			end
			B_DATA: begin
				emit  = out_free;
				n_out = '{out_byte: cmd_q.data, last_in_run: 1'b1};
				if (out_free) begin
					n_phase = B_IDLE;
				end
			end
			B_END: begin
				emit  = out_free;
				n_out = '{out_byte: end_byte(end_idx_q), last_in_run: end_idx_q == END_LAST};
				if (out_free) begin
					n_end_idx = end_idx_q + 3'd1;
					if (end_idx_q == END_LAST) begin
						n_phase = B_IDLE;
					end
				end
			end
			default: begin
				n_phase = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		delay_q   <= n_delay;
		end_idx_q <= n_end_idx;
		if (emit) begin
			out_q <= n_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= n_phase;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/midi_channel_mask_filter_unit.sv
// Path: an accepted request is written to the command queue, loaded into the
//   emitter's command register and then registered in the output stage.
// Throughput: one output byte per cycle within a run unless out_stall holds it;
//   the emitter loads each command from idle; a request yields one command at most.
// Input is taken every cycle while the command queue has room.
// Reset: asynchronous, clears parser, queue and output stage; mask resets to 0xFFFF.
// ----------------------------------------------------------------------------
// midi_channel_mask_filter_unit
// Channel mask filter for a delta-timed MIDI byte stream: parser front end,
// command queue and byte emitter back end.
// ----------------------------------------------------------------------------
module midi_channel_mask_filter_unit import mcmf_pkg::*; #(
	parameter int unsigned MAX_DELAY_UNITS = MAX_DELAY_UNITS_DEF,
	parameter int unsigned QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	cmd_t head;
	logic empty;

	mcmf_front #(
		.MAX_DELAY_UNITS(MAX_DELAY_UNITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full)
	);

	mcmf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (full),
		.pop     (pop),
		.head    (head),
		.empty   (empty)
	);

	mcmf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head     (head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

// File: rtl/core/mcmf_checker.sv
// ----------------------------------------------------------------------------
// mcmf_checker
// Port-level checks for the MIDI channel filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcmf_checker import mcmf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	`ASSERT_CLK_RST(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled output request changed")
	`ASSERT_CLK_RST(a_run_continues, clk, arst_n, out_valid && !out_stall && !out_data.last_in_run |=> out_valid, "gap inside an output run")
	`ASSERT_CLK(a_reset_quiet, clk, $rose(arst_n) |-> !out_valid, "output valid out of reset")
	`ASSERT_CLK_RST(a_in_hold, clk, arst_n, in_valid && in_stall |=> in_valid && $stable(in_data), "stalled input request changed")

endmodule

bind midi_channel_mask_filter_unit mcmf_checker u_mcmf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);
